// File: hdl/vgairq_pkg.sv
// shared types, codes and constant tables of the video gate array block
// no dependencies; imported by the front end, queue, back end and top level
package vgairq_pkg;

  localparam int INK_ENTRIES = 17;
  localparam int INK_IDX_W   = 5;
  localparam logic [INK_IDX_W-1:0] BORDER_IDX = INK_IDX_W'(INK_ENTRIES - 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [2:0] {
    OP_PORT_WRITE = 3'd0,
    OP_HSYNC      = 3'd1,
    OP_FRAME      = 3'd2,
    OP_IRQ_ACK    = 3'd3,
    OP_PIXEL      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_PEN  = 2'd0,
    REG_INK  = 2'd1,
    REG_CTRL = 2'd2,
    REG_BANK = 2'd3
  } reg_sel_t;

  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,
    JOB_INK    = 2'd1,
    JOB_PIXEL  = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic       irq_fired;
    logic       irq_pending;
    logic       vsync_active;
    logic [1:0] video_mode;
    logic       rom_lower;
    logic       rom_upper;
    logic [2:0] ram_config;
  } status_t;

  typedef struct packed {
    job_kind_t             kind;
    status_t               status;
    logic [7:0]            data;
    logic [INK_IDX_W-1:0]  ink_idx;
    logic [4:0]            ink_val;
  } job_t;

  localparam logic [4:0] INK_RESET [INK_ENTRIES] = '{
    5'd1, 5'd24, 5'd20, 5'd6, 5'd26, 5'd0, 5'd2, 5'd8, 5'd10,
    5'd12, 5'd14, 5'd16, 5'd18, 5'd22, 5'd24, 5'd16, 5'd6
  };

  localparam logic [23:0] HW_COLOUR [32] = '{
    24'hACACAC, 24'hACACAC, 24'h00FFAC, 24'hFFFFAC,
    24'h0000AC, 24'hFF00AC, 24'h00ACAC, 24'hFFACAC,
    24'hFF00AC, 24'hFFFFAC, 24'hFFFF00, 24'hFFFFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFAC00, 24'hFFACFF,
    24'h0000AC, 24'h00FFAC, 24'h00FF00, 24'h00FFFF,
    24'h000000, 24'h0000FF, 24'h00AC00, 24'h00ACFF,
    24'hAC00AC, 24'hACFFAC, 24'hACFF00, 24'hACFFFF,
    24'hAC0000, 24'hAC00FF, 24'hACAC00, 24'hACACFF
  };

endpackage

// File: hdl/vgairq_front.sv
// front end: accepts items, owns the control registers and line counter,
// and turns each item into a job for the queue; uses vgairq_pkg
module vgairq_front import vgairq_pkg::*; #(
  parameter int IRQ_PERIOD = 52
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_port_address,
  input  logic [7:0]  in_data_byte,
  input  logic [9:0]  in_vsync_line,
  input  logic [3:0]  in_vsync_length,
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  localparam logic [5:0] PERIOD = 6'(IRQ_PERIOD);

  logic [4:0] pen_r, pen_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       roml_r, roml_nxt;
  logic       romu_r, romu_nxt;
  logic [2:0] bank_r, bank_nxt;
  logic [5:0] line_r, line_nxt;
  logic       irq_r, irq_nxt;
  logic       vs_r, vs_nxt;
  logic [3:0] vrem_r, vrem_nxt;
  logic [9:0] scan_r, scan_nxt;
  logic       fired;
  logic       ink_wr;
  logic [5:0] lc;

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  always_comb begin
    pen_nxt  = pen_r;
    mode_nxt = mode_r;
    roml_nxt = roml_r;
    romu_nxt = romu_r;
    bank_nxt = bank_r;
    line_nxt = line_r;
    irq_nxt  = irq_r;
    vs_nxt   = vs_r;
    vrem_nxt = vrem_r;
    scan_nxt = scan_r;
    fired    = 1'b0;
    ink_wr   = 1'b0;
    lc       = line_r;
    unique case (op_t'(in_operation))
      OP_PORT_WRITE: begin
        if (in_port_address[15:14] == 2'b01) begin
          unique case (reg_sel_t'(in_data_byte[7:6]))
            REG_PEN: pen_nxt = in_data_byte[4:0];
            REG_INK: ink_wr = 1'b1;
            REG_CTRL: begin
              mode_nxt = in_data_byte[1:0];
              roml_nxt = ~in_data_byte[2];
              romu_nxt = ~in_data_byte[3];
              if (in_data_byte[4]) begin
                line_nxt = '0;
                irq_nxt  = 1'b0;
              end
            end
            REG_BANK: bank_nxt = in_data_byte[2:0];
            default: ;
          endcase
        end
      end
      OP_HSYNC: begin
        if (scan_r == in_vsync_line) begin
          lc       = (line_r < 6'd32) ? 6'd0 : 6'd32;
          irq_nxt  = 1'b0;
          vs_nxt   = 1'b1;
          vrem_nxt = (in_vsync_length != 4'd0) ? in_vsync_length : 4'd4;
        end
        if (vs_nxt && vrem_nxt != 4'd0) begin
          vrem_nxt = vrem_nxt - 4'd1;
          if (vrem_nxt == 4'd0) vs_nxt = 1'b0;
        end
        lc = lc + 6'd1;
        if (lc >= PERIOD) begin
          lc      = '0;
          irq_nxt = 1'b1;
          fired   = 1'b1;
        end
        line_nxt = lc;
        if (scan_r != 10'h3FF) scan_nxt = scan_r + 10'd1;
      end
      OP_FRAME: begin
        scan_nxt = '0;
        vs_nxt   = 1'b0;
        vrem_nxt = '0;
      end
      OP_IRQ_ACK: irq_nxt = 1'b0;
      OP_PIXEL: ;
      default: ;
    endcase
  end

  always_comb begin
    job.kind    = ink_wr ? JOB_INK :
                  (op_t'(in_operation) == OP_PIXEL) ? JOB_PIXEL : JOB_STATUS;
    job.status.irq_fired    = fired;
    job.status.irq_pending  = irq_nxt;
    job.status.vsync_active = vs_nxt;
    job.status.video_mode   = mode_nxt;
    job.status.rom_lower    = roml_nxt;
    job.status.rom_upper    = romu_nxt;
    job.status.ram_config   = bank_nxt;
    job.data    = in_data_byte;
    job.ink_idx = pen_r[4] ? BORDER_IDX : {1'b0, pen_r[3:0]};
    job.ink_val = in_data_byte[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r  <= '0;
      mode_r <= 2'd1;
      roml_r <= 1'b1;
      romu_r <= 1'b1;
      bank_r <= '0;
      line_r <= '0;
      irq_r  <= 1'b0;
      vs_r   <= 1'b0;
      vrem_r <= '0;
      scan_r <= '0;
    end else if (push) begin
      pen_r  <= pen_nxt;
      mode_r <= mode_nxt;
      roml_r <= roml_nxt;
      romu_r <= romu_nxt;
      bank_r <= bank_nxt;
      line_r <= line_nxt;
      irq_r  <= irq_nxt;
      vs_r   <= vs_nxt;
      vrem_r <= vrem_nxt;
      scan_r <= scan_nxt;
    end
  end

endmodule

// File: hdl/vgairq_queue.sv
// short job queue between front end and back end
// uses job_t and depth constants from vgairq_pkg
module vgairq_queue import vgairq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam logic [QPTR_W:0] DEPTH = (QPTR_W + 1)'(QUEUE_DEPTH);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == DEPTH);
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

endmodule

// File: hdl/vgairq_back.sv
// back end: owns the ink table, applies ink writes and expands jobs into
// result words, one per cycle unless the receiver stalls, into the output register; uses vgairq_pkg
module vgairq_back import vgairq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_irq_fired,
  output logic        out_irq_pending,
  output logic        out_vsync_active,
  output logic [1:0]  out_video_mode,
  output logic        out_rom_lower_enabled,
  output logic        out_rom_upper_enabled,
  output logic [2:0]  out_ram_config,
  output logic [23:0] out_pixel_color,
  output logic        out_pixel_valid,
  output logic        out_last
);

  logic [4:0]           ink_r [INK_ENTRIES];
  logic [2:0]           step_r, step_nxt;
  logic                 ovalid_r;
  status_t              ostat_r;
  logic [23:0]          ocolor_r;
  logic                 opix_r;
  logic                 olast_r;
  logic                 emit;
  logic                 is_pix;
  logic                 last_step;
  logic [INK_IDX_W-1:0] pen;
  logic [7:0]           d;
  logic [2:0]           p;
  logic [1:0]           q;

  assign emit      = head_valid & (~ovalid_r | ~out_stall);
  assign is_pix    = (head_job.kind == JOB_PIXEL);
  assign last_step = ~is_pix |
                     (head_job.status.video_mode[1] ? (step_r == 3'd7) : (step_r == 3'd3));
  assign pop       = emit & last_step;

  // pen of the pixel at the current step
  always_comb begin
    d = head_job.data;
    p = step_r;
    q = step_r[1:0];
    unique case (head_job.status.video_mode)
      2'd0: pen = p[1] ? {1'b0, d[0], d[4], d[2], d[6]} : {1'b0, d[1], d[5], d[3], d[7]};
      2'd1: pen = {3'b000, d[3'd3 - {1'b0, q}], d[3'd7 - {1'b0, q}]};
      2'd2: pen = {4'b0000, d[3'd7 - p]};
      default: pen = BORDER_IDX;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (emit) step_nxt = last_step ? 3'd0 : step_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < INK_ENTRIES; i++) ink_r[i] <= INK_RESET[i];
      step_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (emit) begin
        ovalid_r <= 1'b1;
        if (head_job.kind == JOB_INK) ink_r[head_job.ink_idx] <= head_job.ink_val;
      end else if (~out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ostat_r  <= head_job.status;
      ocolor_r <= is_pix ? HW_COLOUR[ink_r[pen]] : 24'h000000;
      opix_r   <= is_pix;
      olast_r  <= last_step;
    end
  end

  assign out_valid             = ovalid_r;
  assign out_irq_fired         = ostat_r.irq_fired;
  assign out_irq_pending       = ostat_r.irq_pending;
  assign out_vsync_active      = ostat_r.vsync_active;
  assign out_video_mode        = ostat_r.video_mode;
  assign out_rom_lower_enabled = ostat_r.rom_lower;
  assign out_rom_upper_enabled = ostat_r.rom_upper;
  assign out_ram_config        = ostat_r.ram_config;
  assign out_pixel_color       = ocolor_r;
  assign out_pixel_valid       = opix_r;
  assign out_last              = olast_r;

endmodule

// File: hdl/video_gate_array_registers_irq.sv
// video gate array: register file, line interrupt counter and pixel decoder
// Items enter on the in_ channel (valid/stall) and results leave on the out_
// channel. Every item except a pixel byte gives one status word with last set;
// a pixel byte gives four words (modes 0 and 1) or eight (modes 2 and 3), one
// per cycle unless the receiver stalls, the last one flagged by out_last.
// Status fields show the state after the item.
// The front end applies port writes, hsync, frame start and interrupt
// acknowledge at acceptance and passes a job to a four-entry queue; the back
// end owns the ink table and drains jobs into the output register. The first
// word passes through a queue slot and then the output register. The back
// end emits one word per cycle while the receiver does not stall. in_stall
// rises only while the queue is full.
// When the receiver stalls, the output word holds and the back end waits;
// the front keeps taking items until the queue fills.
// Reset (rst_n low, synchronous) loads the firmware ink colours, mode 1,
// both ROMs enabled, and empties queue and output register.
// uses vgairq_pkg, vgairq_front, vgairq_queue, vgairq_back
module video_gate_array_registers_irq import vgairq_pkg::*; #(
  parameter int IRQ_PERIOD = 52
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_port_address,
  input  logic [7:0]  in_data_byte,
  input  logic [9:0]  in_vsync_line,
  input  logic [3:0]  in_vsync_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_irq_fired,
  output logic        out_irq_pending,
  output logic        out_vsync_active,
  output logic [1:0]  out_video_mode,
  output logic        out_rom_lower_enabled,
  output logic        out_rom_upper_enabled,
  output logic [2:0]  out_ram_config,
  output logic [23:0] out_pixel_color,
  output logic        out_pixel_valid,
  output logic        out_last
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  vgairq_front #(.IRQ_PERIOD(IRQ_PERIOD)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_port_address (in_port_address),
    .in_data_byte    (in_data_byte),
    .in_vsync_line   (in_vsync_line),
    .in_vsync_length (in_vsync_length),
    .q_full          (q_full),
    .push            (push),
    .job             (push_job)
  );

  vgairq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  vgairq_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head_valid            (head_valid),
    .head_job              (head_job),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_irq_fired         (out_irq_fired),
    .out_irq_pending       (out_irq_pending),
    .out_vsync_active      (out_vsync_active),
    .out_video_mode        (out_video_mode),
    .out_rom_lower_enabled (out_rom_lower_enabled),
    .out_rom_upper_enabled (out_rom_upper_enabled),
    .out_ram_config        (out_ram_config),
    .out_pixel_color       (out_pixel_color),
    .out_pixel_valid       (out_pixel_valid),
    .out_last              (out_last)
  );

endmodule

// File: hdl/vgairq_checker.sv
// port-level checks for the video gate array top level
// bound to video_gate_array_registers_irq; no package use
module vgairq_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_irq_fired,
  input logic        out_irq_pending,
  input logic [23:0] out_pixel_color,
  input logic        out_pixel_valid,
  input logic        out_last
);

  // a held word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_color) && $stable(out_last))
    else $error("output word changed while stalled");

  // status words stand alone
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |-> out_last && out_pixel_color == 24'h000000)
    else $error("status word without last or with colour");

  // a pixel word never reports a fresh interrupt; only hsync fires one
  a_pix_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_valid |-> !out_irq_fired)
    else $error("pixel word reports interrupt");

  // a fired interrupt is pending in the same word
  a_fire_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_fired |-> out_irq_pending)
    else $error("interrupt fired but not pending");

endmodule

bind video_gate_array_registers_irq vgairq_port_checks u_vgairq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_irq_fired   (out_irq_fired),
  .out_irq_pending (out_irq_pending),
  .out_pixel_color (out_pixel_color),
  .out_pixel_valid (out_pixel_valid),
  .out_last        (out_last)
);
